// ===== hdl/dpb_pkg.sv =====
// Shared constants, op codes and controller/datapath interface types.
`timescale 1ns / 1ps

package dpb_pkg;

    localparam int STORE_DEPTH = 128;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int FRAC_BITS   = 16;
    localparam int VAL_W       = 32;
    localparam int MAXP_W      = 8;
    localparam int ZB_W        = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int OP_W        = 2;

    localparam logic [OP_W-1:0] OP_ADD_X    = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD_AUTO = 2'd1;
    localparam logic [OP_W-1:0] OP_READ     = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP      = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_POINTS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_BAND  = 1'd1;

    localparam logic [MAXP_W-1:0] MAXP_RESET = 8'd0;
    localparam logic [ZB_W-1:0]   ZB_RESET   = 16'd6;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic pair_rd;
        logic pair_wr;
        logic load_out;
    } dpb_cmd_t;

    typedef struct packed {
        logic halve_go;
        logic last_pair;
    } dpb_status_t;

endpackage

// ===== hdl/decimating_point_buffer.sv =====
// Top level of the decimating point buffer: controller plus datapath.
// After the input transfer the item is registered and executed, then its result is loaded into the output registers;
// a halving add first walks the averaged pairs, reading each pair from the store and then writing its average.
// One item in flight at a time: a new input is taken only after the previous result has been loaded.
// Reset: aresetn synchronous active low; clears count, extremes, config to defaults.
// The point store has no reset; entries are read only after being written.
`timescale 1ns / 1ps

module decimating_point_buffer
    import dpb_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [OP_W-1:0]         s_op,
    input  logic signed [VAL_W-1:0] s_x_value,
    input  logic signed [VAL_W-1:0] s_y_value,
    input  logic [ADDR_W-1:0]       s_read_index,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_accepted,
    output logic [CNT_W-1:0]        m_point_count,
    output logic signed [VAL_W-1:0] m_min_x_seen,
    output logic signed [VAL_W-1:0] m_max_x_seen,
    output logic signed [VAL_W-1:0] m_min_y_seen,
    output logic signed [VAL_W-1:0] m_max_y_seen,
    output logic signed [VAL_W-1:0] m_read_x,
    output logic signed [VAL_W-1:0] m_read_y,
    output logic                    m_read_valid
);

    dpb_cmd_t    cmd;
    dpb_status_t status;

    dpb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    dpb_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_op          (s_op),
        .s_x_value     (s_x_value),
        .s_y_value     (s_y_value),
        .s_read_index  (s_read_index),
        .m_accepted    (m_accepted),
        .m_point_count (m_point_count),
        .m_min_x_seen  (m_min_x_seen),
        .m_max_x_seen  (m_max_x_seen),
        .m_min_y_seen  (m_min_y_seen),
        .m_max_y_seen  (m_max_y_seen),
        .m_read_x      (m_read_x),
        .m_read_y      (m_read_y),
        .m_read_valid  (m_read_valid)
    );

endmodule

// ===== hdl/dpb_ctrl.sv =====
// Controller state machine: sequences the add/read step, halving walk and result transfer.
`timescale 1ns / 1ps

module dpb_ctrl
    import dpb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    input  dpb_status_t status,
    output dpb_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_HRD  = 3'd2;
    localparam logic [2:0] ST_HWR  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = status.halve_go ? ST_HRD : ST_OUT;
            end
            ST_HRD: begin
                cmd.pair_rd = 1'b1;
                state_next  = ST_HWR;
            end
            ST_HWR: begin
                cmd.pair_wr = 1'b1;
                state_next  = status.last_pair ? ST_OUT : ST_HRD;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== hdl/dpb_datapath.sv =====
// Datapath: point store, count, extremes, config registers and result registers.
`timescale 1ns / 1ps

module dpb_datapath
    import dpb_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  dpb_cmd_t                cmd,
    output dpb_status_t             status,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata,
    input  logic [OP_W-1:0]         s_op,
    input  logic signed [VAL_W-1:0] s_x_value,
    input  logic signed [VAL_W-1:0] s_y_value,
    input  logic [ADDR_W-1:0]       s_read_index,
    output logic                    m_accepted,
    output logic [CNT_W-1:0]        m_point_count,
    output logic signed [VAL_W-1:0] m_min_x_seen,
    output logic signed [VAL_W-1:0] m_max_x_seen,
    output logic signed [VAL_W-1:0] m_min_y_seen,
    output logic signed [VAL_W-1:0] m_max_y_seen,
    output logic signed [VAL_W-1:0] m_read_x,
    output logic signed [VAL_W-1:0] m_read_y,
    output logic                    m_read_valid
);

    localparam logic signed [VAL_W:0] ONE_W     = (VAL_W+1)'(1) <<< FRAC_BITS;
    localparam logic signed [VAL_W:0] VMAX_W    = (VAL_W+1)'({1'b0, {(VAL_W-1){1'b1}}});
    localparam logic signed [VAL_W:0] VMIN_W    = -VMAX_W - (VAL_W+1)'(1);

    function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [VAL_W:0] v);
        logic signed [VAL_W-1:0] r;
        if (v > VMAX_W) begin
            r = VMAX_W[VAL_W-1:0];
        end else if (v < VMIN_W) begin
            r = VMIN_W[VAL_W-1:0];
        end else begin
            r = v[VAL_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [VAL_W-1:0] floor_avg(input logic signed [VAL_W-1:0] a,
                                                        input logic signed [VAL_W-1:0] b);
        logic signed [VAL_W:0] s;
        s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
        return s[VAL_W:1];
    endfunction

    logic signed [VAL_W-1:0] x_mem [STORE_DEPTH];
    logic signed [VAL_W-1:0] y_mem [STORE_DEPTH];

    logic [MAXP_W-1:0]       max_points_reg;
    logic [ZB_W-1:0]         zero_band_reg;
    logic [OP_W-1:0]         op_reg;
    logic signed [VAL_W-1:0] xin_reg, yin_reg;
    logic [ADDR_W-1:0]       idx_reg;
    logic [CNT_W-1:0]        count_reg;
    logic                    seeded_reg;
    logic signed [VAL_W-1:0] min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    logic signed [VAL_W-1:0] last_x_reg;
    logic [ADDR_W-1:0]       k_reg;
    logic                    odd_reg;
    logic [CNT_W-1:0]        m_reg;
    logic                    accepted_reg, rv_reg;
    logic signed [VAL_W-1:0] rda_x_reg, rda_y_reg, rdb_x_reg, rdb_y_reg;

    logic signed [VAL_W-1:0] auto_x, x_eff;
    logic signed [VAL_W:0]   y_w, zb_w;
    logic                    is_add, in_band, dup, full, add_ok;
    logic [CNT_W-1:0]        count_inc;
    logic signed [VAL_W-1:0] w_min_x, w_max_x, w_min_y, w_max_y;
    logic signed [VAL_W-1:0] n_min_x, n_max_x, n_min_y, n_max_y;
    logic signed [VAL_W-1:0] ax, ay;
    logic [ADDR_W-1:0]       hi_addr, lo_addr, rd_a_addr, wr_addr;
    logic                    wr_en, rd_en;
    logic signed [VAL_W-1:0] wr_x, wr_y;
    logic                    first_pair;

    // add decision
    always_comb begin
        auto_x    = (count_reg == '0) ? '0 : sat_val({last_x_reg[VAL_W-1], last_x_reg} + ONE_W);
        x_eff     = (op_reg == OP_ADD_AUTO) ? auto_x : xin_reg;
        y_w       = {yin_reg[VAL_W-1], yin_reg};
        zb_w      = (VAL_W+1)'(zero_band_reg);
        is_add    = (op_reg == OP_ADD_X) || (op_reg == OP_ADD_AUTO);
        in_band   = (y_w > -zb_w) && (y_w < zb_w);
        dup       = (count_reg != '0) && (last_x_reg == x_eff);
        full      = (count_reg >= CNT_W'(STORE_DEPTH));
        add_ok    = is_add && !in_band && !dup && !full;
        count_inc = count_reg + CNT_W'(1);
    end

    // extremes after an add
    always_comb begin
        w_min_x = (x_eff < min_x_reg) ? x_eff : min_x_reg;
        w_max_x = (x_eff > max_x_reg) ? x_eff : max_x_reg;
        w_min_y = (yin_reg < min_y_reg) ? yin_reg : min_y_reg;
        w_max_y = (yin_reg > max_y_reg) ? yin_reg : max_y_reg;
        if (!seeded_reg) begin
            n_min_x = x_eff;
            n_max_x = x_eff;
            n_min_y = yin_reg;
            n_max_y = yin_reg;
        end else begin
            n_min_x = w_min_x;
            n_max_x = w_max_x;
            if (w_min_y == w_max_y) begin
                n_min_y = sat_val({w_min_y[VAL_W-1], w_min_y} - ONE_W);
                n_max_y = sat_val({w_max_y[VAL_W-1], w_max_y} + ONE_W);
            end else begin
                n_min_y = w_min_y;
                n_max_y = w_max_y;
            end
        end
    end

    // halving walk
    always_comb begin
        hi_addr    = ADDR_W'({k_reg, 1'b1}) - ADDR_W'(odd_reg);
        lo_addr    = hi_addr - ADDR_W'(1);
        ax         = floor_avg(rdb_x_reg, rda_x_reg);
        ay         = floor_avg(rdb_y_reg, rda_y_reg);
        first_pair = (k_reg == ADDR_W'(odd_reg));
        rd_a_addr  = cmd.pair_rd ? lo_addr : idx_reg;
        rd_en      = cmd.pair_rd || cmd.exec;
        wr_en      = cmd.pair_wr || (cmd.exec && add_ok);
        wr_addr    = cmd.pair_wr ? k_reg : count_reg[ADDR_W-1:0];
        wr_x       = cmd.pair_wr ? ax : x_eff;
        wr_y       = cmd.pair_wr ? ay : yin_reg;
    end

    assign status.halve_go  = add_ok && (count_inc == CNT_W'(max_points_reg))
                              && (count_inc >= CNT_W'(2));
    assign status.last_pair = ({1'b0, k_reg} + CNT_W'(1)) == m_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            x_mem[wr_addr] <= wr_x;
            y_mem[wr_addr] <= wr_y;
        end
        if (rd_en) begin
            rda_x_reg <= x_mem[rd_a_addr];
            rda_y_reg <= y_mem[rd_a_addr];
            rdb_x_reg <= x_mem[hi_addr];
            rdb_y_reg <= y_mem[hi_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_points_reg <= MAXP_RESET;
            zero_band_reg  <= ZB_RESET;
            count_reg      <= '0;
            seeded_reg     <= 1'b0;
            min_x_reg      <= '0;
            max_x_reg      <= '0;
            min_y_reg      <= '0;
            max_y_reg      <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_MAX_POINTS: max_points_reg <= cfg_wdata[MAXP_W-1:0];
                    REG_ZERO_BAND:  zero_band_reg  <= cfg_wdata[ZB_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.exec && add_ok) begin
                count_reg  <= count_inc;
                seeded_reg <= 1'b1;
                min_x_reg  <= n_min_x;
                max_x_reg  <= n_max_x;
                min_y_reg  <= n_min_y;
                max_y_reg  <= n_max_y;
            end
            if (cmd.pair_wr) begin
                if (first_pair) begin
                    min_x_reg <= ax;
                    max_x_reg <= ax;
                    min_y_reg <= ay;
                    max_y_reg <= ay;
                end else begin
                    if (ax < min_x_reg) min_x_reg <= ax;
                    if (ax > max_x_reg) max_x_reg <= ax;
                    if (ay < min_y_reg) min_y_reg <= ay;
                    if (ay > max_y_reg) max_y_reg <= ay;
                end
                if (status.last_pair) begin
                    count_reg <= m_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg  <= s_op;
            xin_reg <= s_x_value;
            yin_reg <= s_y_value;
            idx_reg <= s_read_index;
        end
        if (cmd.exec) begin
            accepted_reg <= add_ok;
            rv_reg       <= (op_reg == OP_READ) && (CNT_W'(idx_reg) < count_reg);
            if (add_ok) begin
                last_x_reg <= x_eff;
            end
            if (status.halve_go) begin
                k_reg   <= ADDR_W'(count_inc[0]);
                odd_reg <= count_inc[0];
                m_reg   <= {1'b0, count_inc[CNT_W-1:1]} + CNT_W'(count_inc[0]);
            end
        end
        if (cmd.pair_wr) begin
            if (status.last_pair) begin
                last_x_reg <= ax;
            end else begin
                k_reg <= k_reg + ADDR_W'(1);
            end
        end
        if (cmd.load_out) begin
            m_accepted    <= accepted_reg;
            m_point_count <= count_reg;
            m_min_x_seen  <= min_x_reg;
            m_max_x_seen  <= max_x_reg;
            m_min_y_seen  <= min_y_reg;
            m_max_y_seen  <= max_y_reg;
            m_read_x      <= rv_reg ? rda_x_reg : '0;
            m_read_y      <= rv_reg ? rda_y_reg : '0;
            m_read_valid  <= rv_reg;
        end
    end

endmodule
